/* hw/rtl/three_rotor_substitution_cipher_defines.svh */
// Assertion macros used by the cipher back end.
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TRSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cipher check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TRSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cipher check failed");
`else
`define TRSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TRSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/trsc_pkg.sv */
package trsc_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned CHAR_W   = 8;
    localparam logic [7:0]  CHAR_A   = 8'd65;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned IN_TUSER_W  = 5;
    localparam int unsigned OUT_TDATA_W = 24;

    // Opcodes carried in tuser.
    localparam logic [1:0] OP_ENCRYPT = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_SET_POS = 2'd2;
    localparam logic [1:0] OP_RESTORE = 2'd3;

    // Table selectors for wiring loads.
    localparam logic [2:0] SEL_RIGHT     = 3'd0;
    localparam logic [2:0] SEL_MIDDLE    = 3'd1;
    localparam logic [2:0] SEL_LEFT      = 3'd2;
    localparam logic [2:0] SEL_REFLECTOR = 3'd3;
    localparam logic [2:0] SEL_PLUGBOARD = 3'd4;

    // Rotor numbers.
    localparam logic [1:0] ROT_RIGHT  = 2'd0;
    localparam logic [1:0] ROT_MIDDLE = 2'd1;
    localparam logic [1:0] ROT_LEFT   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEFT_START   = 2'd0;
    localparam logic [1:0] CFG_MIDDLE_START = 2'd1;
    localparam logic [1:0] CFG_RIGHT_START  = 2'd2;

    // Lookup steps of one ciphered letter.
    localparam logic [3:0] STEP_PLUG_IN  = 4'd0;
    localparam logic [3:0] STEP_REFLECT  = 4'd4;
    localparam logic [3:0] STEP_PLUG_OUT = 4'd8;

    // Queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        K_PASS       = 3'd0,
        K_CIPHER     = 3'd1,
        K_LOAD_ROTOR = 3'd2,
        K_LOAD_REFL  = 3'd3,
        K_LOAD_PLUG  = 3'd4,
        K_SET        = 3'd5,
        K_RESTORE    = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   char_in;
        logic [LETTER_W-1:0] letter;
        logic [1:0]          rotor;
        logic [LETTER_W-1:0] idx;
        logic [LETTER_W-1:0] val;
        logic [LETTER_W-1:0] set_left;
        logic [LETTER_W-1:0] set_middle;
        logic [LETTER_W-1:0] set_right;
    } t_item;

    // Rotor whose table a lookup step reads.
    function automatic logic [1:0] rotor_of_step(input logic [3:0] step);
        logic [1:0] rot;
        rot = ROT_RIGHT;
        if (step == 4'd2 || step == 4'd6) begin
            rot = ROT_MIDDLE;
        end else if (step == 4'd3 || step == 4'd5) begin
            rot = ROT_LEFT;
        end
        return rot;
    endfunction

    function automatic logic step_forward(input logic [3:0] step);
        return step inside {[4'd1:4'd3]};
    endfunction

    function automatic logic step_reverse(input logic [3:0] step);
        return step inside {[4'd5:4'd7]};
    endfunction

endpackage

/* hw/rtl/trsc_front.sv */
module trsc_front #(
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [trsc_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic [trsc_pkg::IN_TUSER_W-1:0]   i_tuser,
    input  logic                              i_q_full,
    output logic                              o_push,
    output trsc_pkg::t_item                   o_item
);

    logic [1:0]                    opcode;
    logic [2:0]                    sel;
    logic [trsc_pkg::CHAR_W-1:0]   ch;
    logic [trsc_pkg::CHAR_W-1:0]   ch_off;
    logic [trsc_pkg::LETTER_W-1:0] idx;
    logic [trsc_pkg::LETTER_W-1:0] val;
    logic                          is_letter;
    logic                          entry_ok;

    assign opcode = i_tuser[1:0];
    assign sel    = i_tuser[4:2];
    assign ch     = i_tdata[7:0];
    assign idx    = i_tdata[12:8];
    assign val    = i_tdata[17:13];
    assign ch_off = ch - trsc_pkg::CHAR_A;

    assign is_letter = (ch >= trsc_pkg::CHAR_A)
                    && (ch < trsc_pkg::CHAR_A + 8'(ALPHABET_SIZE));
    assign entry_ok  = ({1'b0, idx} < 6'(ALPHABET_SIZE))
                    && ({1'b0, val} < 6'(ALPHABET_SIZE));

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item            = '0;
        o_item.char_in    = ch;
        o_item.letter     = ch_off[4:0];
        o_item.rotor      = sel[1:0];
        o_item.idx        = idx;
        o_item.val        = val;
        o_item.set_left   = i_tdata[22:18];
        o_item.set_middle = i_tdata[27:23];
        o_item.set_right  = i_tdata[32:28];
        o_item.kind       = trsc_pkg::K_PASS;
        case (opcode)
            trsc_pkg::OP_ENCRYPT: begin
                if (is_letter) begin
                    o_item.kind = trsc_pkg::K_CIPHER;
                end
            end
            trsc_pkg::OP_LOAD: begin
                // Out-of-range entries and unused selectors echo only.
                if (entry_ok) begin
                    if (sel inside {trsc_pkg::SEL_RIGHT, trsc_pkg::SEL_MIDDLE,
                                    trsc_pkg::SEL_LEFT}) begin
                        o_item.kind = trsc_pkg::K_LOAD_ROTOR;
                    end else if (sel == trsc_pkg::SEL_REFLECTOR) begin
                        o_item.kind = trsc_pkg::K_LOAD_REFL;
                    end else if (sel == trsc_pkg::SEL_PLUGBOARD) begin
                        o_item.kind = trsc_pkg::K_LOAD_PLUG;
                    end
                end
            end
            trsc_pkg::OP_SET_POS: begin
                o_item.kind = trsc_pkg::K_SET;
            end
            trsc_pkg::OP_RESTORE: begin
                o_item.kind = trsc_pkg::K_RESTORE;
            end
            default: begin
                o_item.kind = trsc_pkg::K_PASS;
            end
        endcase
    end

endmodule

/* hw/rtl/trsc_queue.sv */
module trsc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  trsc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output trsc_pkg::t_item o_item,
    output logic            o_empty
);

    localparam int unsigned PTR_W = $clog2(trsc_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(trsc_pkg::QUEUE_DEPTH + 1);

    trsc_pkg::t_item r_mem [trsc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(trsc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(trsc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(trsc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* hw/rtl/trsc_tbl.sv */
module trsc_tbl #(
    parameter int unsigned DEPTH = 78
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [trsc_pkg::LETTER_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    input  logic [trsc_pkg::LETTER_W-1:0] i_id,
    output logic [trsc_pkg::LETTER_W-1:0] o_rdata
);

    // Entries never written read back as the identity value given with the read.
    logic [trsc_pkg::LETTER_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]              r_valid;
    logic [trsc_pkg::LETTER_W-1:0] r_q;
    logic [trsc_pkg::LETTER_W-1:0] r_id;
    logic                          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q  <= r_mem[i_raddr];
            r_id <= i_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_hit <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_hit ? r_q : r_id;

endmodule

/* hw/rtl/trsc_back.sv */
`include "three_rotor_substitution_cipher_defines.svh"

module trsc_back #(
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trsc_pkg::t_item               i_item,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [trsc_pkg::LETTER_W-1:0] i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [trsc_pkg::CHAR_W-1:0]   o_out_char,
    output logic [trsc_pkg::LETTER_W-1:0] o_out_left,
    output logic [trsc_pkg::LETTER_W-1:0] o_out_middle,
    output logic [trsc_pkg::LETTER_W-1:0] o_out_right
);

    localparam int unsigned RA_W = $clog2(3 * ALPHABET_SIZE);
    localparam int unsigned PA_W = $clog2(2 * ALPHABET_SIZE);
    localparam logic [RA_W-1:0] BASE_MID  = RA_W'(ALPHABET_SIZE);
    localparam logic [RA_W-1:0] BASE_LEFT = RA_W'(2 * ALPHABET_SIZE);
    localparam logic [PA_W-1:0] BASE_PLUG = PA_W'(ALPHABET_SIZE);
    localparam logic [4:0]      LAST_POS  = 5'(ALPHABET_SIZE - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // Reduction of a 5-bit position modulo the alphabet size.
    logic [4:0] fold_lut [32];
    for (genvar g = 0; g < 32; g++) begin : g_fold
        assign fold_lut[g] = 5'(g % ALPHABET_SIZE);
    end

    function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'(ALPHABET_SIZE)) begin
            s = s - 6'(ALPHABET_SIZE);
        end
        return s[4:0];
    endfunction

    function automatic logic [4:0] sub_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + 6'(ALPHABET_SIZE) - {1'b0, b};
        end
        return s[4:0];
    endfunction

    function automatic logic [4:0] pos_sel(input logic [1:0] rot, input logic [4:0] pr,
                                           input logic [4:0] pm, input logic [4:0] pl);
        logic [4:0] p;
        case (rot)
            trsc_pkg::ROT_RIGHT:  p = pr;
            trsc_pkg::ROT_MIDDLE: p = pm;
            trsc_pkg::ROT_LEFT:   p = pl;
            default:              p = pr;
        endcase
        return p;
    endfunction

    function automatic logic [RA_W-1:0] rotor_base(input logic [1:0] rot);
        logic [RA_W-1:0] b;
        case (rot)
            trsc_pkg::ROT_MIDDLE: b = BASE_MID;
            trsc_pkg::ROT_LEFT:   b = BASE_LEFT;
            default:              b = '0;
        endcase
        return b;
    endfunction

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [4:0] r_pos_left, n_pos_left;
    logic [4:0] r_pos_middle, n_pos_middle;
    logic [4:0] r_pos_right, n_pos_right;
    logic [4:0] r_start_left, n_start_left;
    logic [4:0] r_start_middle, n_start_middle;
    logic [4:0] r_start_right, n_start_right;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic [4:0] r_out_left, n_out_left;
    logic [4:0] r_out_middle, n_out_middle;
    logic [4:0] r_out_right, n_out_right;

    logic            out_free;
    logic            load_out;
    logic [7:0]      out_char;
    logic [4:0]      d;
    logic [4:0]      s;
    logic [4:0]      key;
    logic [3:0]      step_nxt;
    logic [1:0]      rot_nxt;
    logic [4:0]      right_inc;
    logic [4:0]      middle_inc;
    logic [4:0]      left_inc;

    logic            fwd_we, rev_we, pr_we;
    logic [RA_W-1:0] fwd_waddr, rev_waddr;
    logic [PA_W-1:0] pr_waddr;
    logic [4:0]      fwd_wdata, rev_wdata, pr_wdata;
    logic            fwd_re, rev_re, pr_re;
    logic [RA_W-1:0] rot_raddr;
    logic [PA_W-1:0] pr_raddr;
    logic [4:0]      rd_id;
    logic [4:0]      fwd_rdata, rev_rdata, pr_rdata;

    trsc_tbl #(.DEPTH(3 * ALPHABET_SIZE)) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (fwd_we),
        .i_waddr (fwd_waddr),
        .i_wdata (fwd_wdata),
        .i_re    (fwd_re),
        .i_raddr (rot_raddr),
        .i_id    (rd_id),
        .o_rdata (fwd_rdata)
    );

    trsc_tbl #(.DEPTH(3 * ALPHABET_SIZE)) u_rev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rev_we),
        .i_waddr (rev_waddr),
        .i_wdata (rev_wdata),
        .i_re    (rev_re),
        .i_raddr (rot_raddr),
        .i_id    (rd_id),
        .o_rdata (rev_rdata)
    );

    // Reflector in the lower half, plugboard in the upper half.
    trsc_tbl #(.DEPTH(2 * ALPHABET_SIZE)) u_pr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (pr_we),
        .i_waddr (pr_waddr),
        .i_wdata (pr_wdata),
        .i_re    (pr_re),
        .i_raddr (pr_raddr),
        .i_id    (rd_id),
        .o_rdata (pr_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // Datapath of one lookup step: undo the rotor offset of the data that just
    // came back, then offset it for the rotor read next.
    always_comb begin
        if (trsc_pkg::step_forward(r_step)) begin
            d = fwd_rdata;
        end else if (trsc_pkg::step_reverse(r_step)) begin
            d = rev_rdata;
        end else begin
            d = pr_rdata;
        end
        if (trsc_pkg::step_forward(r_step) || trsc_pkg::step_reverse(r_step)) begin
            s = sub_mod(d, pos_sel(trsc_pkg::rotor_of_step(r_step),
                                   r_pos_right, r_pos_middle, r_pos_left));
        end else begin
            s = d;
        end
        step_nxt = r_step + 4'd1;
        rot_nxt  = trsc_pkg::rotor_of_step(step_nxt);
        if (trsc_pkg::step_forward(step_nxt) || trsc_pkg::step_reverse(step_nxt)) begin
            key = add_mod(s, pos_sel(rot_nxt, r_pos_right, r_pos_middle, r_pos_left));
        end else begin
            key = s;
        end
    end

    assign right_inc  = (r_pos_right == LAST_POS) ? '0 : r_pos_right + 5'd1;
    assign middle_inc = (r_pos_middle == LAST_POS) ? '0 : r_pos_middle + 5'd1;
    assign left_inc   = (r_pos_left == LAST_POS) ? '0 : r_pos_left + 5'd1;
    assign out_char   = trsc_pkg::CHAR_A + {3'b000, s};

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_pos_left     = r_pos_left;
        n_pos_middle   = r_pos_middle;
        n_pos_right    = r_pos_right;
        n_start_left   = r_start_left;
        n_start_middle = r_start_middle;
        n_start_right  = r_start_right;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_char     = r_out_char;
        n_out_left     = r_out_left;
        n_out_middle   = r_out_middle;
        n_out_right    = r_out_right;
        load_out       = 1'b0;
        o_pop          = 1'b0;

        fwd_we    = 1'b0;
        rev_we    = 1'b0;
        pr_we     = 1'b0;
        fwd_waddr = rotor_base(i_item.rotor) + RA_W'(i_item.idx);
        fwd_wdata = i_item.val;
        rev_waddr = rotor_base(i_item.rotor) + RA_W'(i_item.val);
        rev_wdata = i_item.idx;
        pr_waddr  = (i_item.kind == trsc_pkg::K_LOAD_PLUG)
                  ? BASE_PLUG + PA_W'(i_item.idx) : PA_W'(i_item.idx);
        pr_wdata  = i_item.val;
        fwd_re    = 1'b0;
        rev_re    = 1'b0;
        pr_re     = 1'b0;
        rot_raddr = rotor_base(rot_nxt) + RA_W'(key);
        pr_raddr  = (step_nxt == trsc_pkg::STEP_PLUG_OUT)
                  ? BASE_PLUG + PA_W'(key) : PA_W'(key);
        rd_id     = key;

        case (r_state)
            S_IDLE: begin
                o_pop = !i_q_empty && (i_item.kind == trsc_pkg::K_CIPHER || out_free);
                if (o_pop) begin
                    out_char_echo: begin
                        n_out_char = i_item.char_in;
                    end
                    case (i_item.kind)
                        trsc_pkg::K_CIPHER: begin
                            pr_re    = 1'b1;
                            pr_raddr = BASE_PLUG + PA_W'(i_item.letter);
                            rd_id    = i_item.letter;
                            n_step   = trsc_pkg::STEP_PLUG_IN;
                            n_state  = S_RUN;
                        end
                        trsc_pkg::K_LOAD_ROTOR: begin
                            fwd_we   = 1'b1;
                            rev_we   = 1'b1;
                            load_out = 1'b1;
                        end
                        trsc_pkg::K_LOAD_REFL, trsc_pkg::K_LOAD_PLUG: begin
                            pr_we    = 1'b1;
                            load_out = 1'b1;
                        end
                        trsc_pkg::K_SET: begin
                            n_pos_left   = fold_lut[i_item.set_left];
                            n_pos_middle = fold_lut[i_item.set_middle];
                            n_pos_right  = fold_lut[i_item.set_right];
                            load_out     = 1'b1;
                        end
                        trsc_pkg::K_RESTORE: begin
                            n_pos_left   = fold_lut[r_start_left];
                            n_pos_middle = fold_lut[r_start_middle];
                            n_pos_right  = fold_lut[r_start_right];
                            load_out     = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                    if (i_item.kind == trsc_pkg::K_CIPHER) begin
                        n_out_char = r_out_char;
                    end
                end
            end
            S_RUN: begin
                if (r_step == trsc_pkg::STEP_PLUG_OUT) begin
                    if (out_free) begin
                        n_out_char  = out_char;
                        n_pos_right = right_inc;
                        if (right_inc == '0) begin
                            n_pos_middle = middle_inc;
                            if (middle_inc == '0) begin
                                n_pos_left = left_inc;
                            end
                        end
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_step = step_nxt;
                    if (trsc_pkg::step_forward(step_nxt)) begin
                        fwd_re = 1'b1;
                    end else if (trsc_pkg::step_reverse(step_nxt)) begin
                        rev_re = 1'b1;
                    end else begin
                        pr_re = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_left   = n_pos_left;
            n_out_middle = n_pos_middle;
            n_out_right  = n_pos_right;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                trsc_pkg::CFG_LEFT_START: begin
                    n_start_left = i_cfg_wdata;
                    n_pos_left   = fold_lut[i_cfg_wdata];
                end
                trsc_pkg::CFG_MIDDLE_START: begin
                    n_start_middle = i_cfg_wdata;
                    n_pos_middle   = fold_lut[i_cfg_wdata];
                end
                trsc_pkg::CFG_RIGHT_START: begin
                    n_start_right = i_cfg_wdata;
                    n_pos_right   = fold_lut[i_cfg_wdata];
                end
                default: begin
                    n_start_left = r_start_left;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= trsc_pkg::STEP_PLUG_IN;
            r_pos_left     <= '0;
            r_pos_middle   <= '0;
            r_pos_right    <= '0;
            r_start_left   <= '0;
            r_start_middle <= '0;
            r_start_right  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_step         <= n_step;
            r_pos_left     <= n_pos_left;
            r_pos_middle   <= n_pos_middle;
            r_pos_right    <= n_pos_right;
            r_start_left   <= n_start_left;
            r_start_middle <= n_start_middle;
            r_start_right  <= n_start_right;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char   <= n_out_char;
        r_out_left   <= n_out_left;
        r_out_middle <= n_out_middle;
        r_out_right  <= n_out_right;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_left   = r_out_left;
    assign o_out_middle = r_out_middle;
    assign o_out_right  = r_out_right;

    `TRSC_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_pos_left} < 6'(ALPHABET_SIZE)) && ({1'b0, r_pos_middle} < 6'(ALPHABET_SIZE)) && ({1'b0, r_pos_right} < 6'(ALPHABET_SIZE)))
    `TRSC_ASSERT_IMP(a_step_in_range, i_clk, i_rst_n, r_state == S_RUN, r_step <= trsc_pkg::STEP_PLUG_OUT)
    `TRSC_ASSERT_NEXT(a_cipher_starts, i_clk, i_rst_n, o_pop && (i_item.kind == trsc_pkg::K_CIPHER), (r_state == S_RUN) && (r_step == trsc_pkg::STEP_PLUG_IN))
    `TRSC_ASSERT_NEXT(a_cipher_result, i_clk, i_rst_n, (r_state == S_RUN) && (r_step == trsc_pkg::STEP_PLUG_OUT) && out_free, o_out_valid && (r_state == S_IDLE) && (o_out_char >= trsc_pkg::CHAR_A) && (o_out_char < trsc_pkg::CHAR_A + 8'(ALPHABET_SIZE)))

endmodule

/* hw/rtl/three_rotor_substitution_cipher.sv */
// Three-rotor substitution cipher over the letters A.. (ALPHABET_SIZE letters from A).
// Every input beat carries an opcode in tuser and yields exactly one output beat:
// encrypt sends a byte through plugboard, right/middle/left rotors, reflector, the
// rotors back and the plugboard again, then steps the right rotor with odometer carry
// (no notches); a byte that is not a letter is echoed and nothing steps. The other
// opcodes load one wiring entry (a rotor load also writes that rotor's reverse
// table), set the current positions, or return the rotors to the start registers;
// they echo the input byte. Every output beat also reports the rotor positions
// after the item. Tables come out of reset as identity mappings. A letter makes nine
// dependent lookups through the registered table ports and holds the engine until
// done; any other item is done in the cycle that dequeues it. A two-entry queue sits
// between the input classifier and the engine, and a one-beat output register
// decouples the engine from the consumer, so the input keeps accepting beats while a
// result waits, until the queue fills. Start registers must be written through the
// configuration port only while the block is idle; the block does not enforce this.
// A write also sets that rotor's current position to the value modulo the alphabet size.
module three_rotor_substitution_cipher #(
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: char_in[7:0], entry_index[12:8], entry_value[17:13],
    // set_left[22:18], set_middle[27:23], set_right[32:28], zero fill to 40 bits.
    input  logic [trsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser from bit 0: opcode[1:0], table_select[4:2].
    input  logic [trsc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,

    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: char_out[7:0], current_left[12:8], current_middle[17:13],
    // current_right[22:18], zero fill to 24 bits.
    output logic [trsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

    // Configuration: 0 left_start, 1 middle_start, 2 right_start.
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [trsc_pkg::LETTER_W-1:0]      i_cfg_wdata
);

    trsc_pkg::t_item front_item;
    trsc_pkg::t_item q_item;
    logic            push;
    logic            q_full;
    logic            q_empty;
    logic            pop;
    logic [7:0]      out_char;
    logic [4:0]      out_left;
    logic [4:0]      out_middle;
    logic [4:0]      out_right;

    // Classifies each beat as it is accepted.
    trsc_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    trsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    // Owns the wiring tables, the rotor positions and the output register.
    trsc_back #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_char   (out_char),
        .o_out_left   (out_left),
        .o_out_middle (out_middle),
        .o_out_right  (out_right)
    );

    assign m_axis_tdata = {1'b0, out_right, out_middle, out_left, out_char};

endmodule
